// File: hdl/assert_macros.svh
// assertion macros used by the rtl top file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge outside reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// antecedent implies consequent in the following cycle
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) ante |=> cons) else $error(msg);

`endif

// File: hdl/ppr_pkg.sv
// types, constants and helpers of the pinhole primary ray block
`timescale 1ns / 1ps

package ppr_pkg;

  localparam int COORD_W  = 12;
  localparam int DIM_W    = 13;
  localparam int TAN_W    = 16;
  localparam int VEC_W    = 16;
  localparam int FRAC     = 14;
  localparam int GUARD    = 8;
  localparam int RND_SH   = FRAC - GUARD;
  localparam int NMAG_W   = 14;
  localparam int UQ_W     = 32;
  localparam int UV_W     = UQ_W + 1;
  localparam int UREM_W   = 14;
  localparam int PROD_W   = VEC_W + UV_W;
  localparam int P_W      = 44;
  localparam int NM_W     = 31;
  localparam int SUM_W    = 2 * NM_W;
  localparam int SQ_STEPS = SUM_W / 2;
  localparam int FN_W     = NM_W + FRAC;
  localparam int FQ_W     = 17;
  localparam int NORM_TOP = 30;

  typedef struct packed {
    logic [COORD_W-1:0] pixel_row;
    logic [COORD_W-1:0] pixel_col;
  } pix_t;

  typedef struct packed {
    logic signed [VEC_W-1:0] dir_z;
    logic signed [VEC_W-1:0] dir_y;
    logic signed [VEC_W-1:0] dir_x;
  } ray_t;

  typedef enum logic [2:0] {
    CFG_WIDTH,
    CFG_HEIGHT,
    CFG_FOV_TAN,
    CFG_VIEW,
    CFG_RIGHT,
    CFG_UP
  } cfg_reg_t;

  // one signed q1.14 component of a packed vector, x in the low bits
  function automatic logic signed [VEC_W-1:0] vec_comp(input logic [3*VEC_W-1:0] v,
                                                       input logic [1:0] idx);
    vec_comp = v[VEC_W*idx +: VEC_W];
  endfunction

  // drop the extra fraction bits, nearest with ties away from zero
  function automatic logic signed [P_W-1:0] round_guard(input logic signed [PROD_W-1:0] x);
    logic [PROD_W-1:0] mag;
    logic [P_W-2:0]    q;
    mag = x[PROD_W-1] ? PROD_W'(-x) : PROD_W'(x);
    q = (P_W-1)'((mag + PROD_W'(1 << (RND_SH - 1))) >> RND_SH);
    round_guard = x[PROD_W-1] ? -$signed({1'b0, q}) : $signed({1'b0, q});
  endfunction

endpackage

// File: hdl/pinhole_primary_ray_direction_top.sv
// pinhole camera primary ray direction, one pixel in and one unit direction out
// throughput: one item per cycle while the skid stage is empty, set by the fully pipelined dividers and square root
// the output register plus a skid stage stall the whole pipeline only once both are full
// synchronous reset clears valid bits and loads the register defaults
`timescale 1ns / 1ps

`include "assert_macros.svh"

module pinhole_primary_ray_direction_top (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  pix_valid,
  output logic                  pix_stall,
  input  ppr_pkg::pix_t         pix,
  output logic                  ray_valid,
  input  logic                  ray_stall,
  output ppr_pkg::ray_t         ray,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [5:0]            paddr,
  input  logic [63:0]           pwdata,
  output logic [63:0]           prdata,
  output logic                  pready
);

  localparam int VW  = ppr_pkg::VEC_W;
  localparam int DW  = ppr_pkg::DIM_W;
  localparam int UQ  = ppr_pkg::UQ_W;
  localparam int UR  = ppr_pkg::UREM_W;
  localparam int PW  = ppr_pkg::P_W;
  localparam int NW  = ppr_pkg::NM_W;
  localparam int SW  = ppr_pkg::SUM_W;
  localparam int SQN = ppr_pkg::SQ_STEPS;
  localparam int FQ  = ppr_pkg::FQ_W;
  localparam int FNW = ppr_pkg::FN_W;
  localparam int CHK = 11;
  localparam int NCH = PW / CHK;

  // configuration registers
  logic [DW-1:0]                 img_w;
  logic [DW-1:0]                 img_h;
  logic [ppr_pkg::TAN_W-1:0]     fov_tan;
  logic [3*VW-1:0]               view_vec;
  logic [3*VW-1:0]               right_vec;
  logic [3*VW-1:0]               up_vec;

  always_ff @(posedge clk) begin
    if (rst) begin
      img_w     <= 13'd640;
      img_h     <= 13'd480;
      fov_tan   <= 16'd4096;
      view_vec  <= '0;
      right_vec <= '0;
      up_vec    <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (ppr_pkg::cfg_reg_t'(paddr[5:3]))
        ppr_pkg::CFG_WIDTH:   img_w     <= pwdata[DW-1:0];
        ppr_pkg::CFG_HEIGHT:  img_h     <= pwdata[DW-1:0];
        ppr_pkg::CFG_FOV_TAN: fov_tan   <= pwdata[ppr_pkg::TAN_W-1:0];
        ppr_pkg::CFG_VIEW:    view_vec  <= pwdata[3*VW-1:0];
        ppr_pkg::CFG_RIGHT:   right_vec <= pwdata[3*VW-1:0];
        ppr_pkg::CFG_UP:      up_vec    <= pwdata[3*VW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (ppr_pkg::cfg_reg_t'(paddr[5:3]))
      ppr_pkg::CFG_WIDTH:   prdata = 64'(img_w);
      ppr_pkg::CFG_HEIGHT:  prdata = 64'(img_h);
      ppr_pkg::CFG_FOV_TAN: prdata = 64'(fov_tan);
      ppr_pkg::CFG_VIEW:    prdata = 64'(view_vec);
      ppr_pkg::CFG_RIGHT:   prdata = 64'(right_vec);
      ppr_pkg::CFG_UP:      prdata = 64'(up_vec);
      default:              prdata = '0;
    endcase
  end

  assign pready = 1'b1;

  // pipeline advance
  logic          skid_v;
  ppr_pkg::ray_t skid_d;
  logic          en;
  assign en        = !skid_v;
  assign pix_stall = skid_v;

  logic [DW-1:0] w_eff;
  assign w_eff = (img_w == '0) ? DW'(1) : img_w;

  // input register
  logic                          s0_v;
  logic [ppr_pkg::COORD_W-1:0]   s0_col, s0_row;

  always_ff @(posedge clk) begin
    if (rst) s0_v <= 1'b0;
    else if (en) s0_v <= pix_valid;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s0_col <= pix.pixel_col;
      s0_row <= pix.pixel_row;
    end
  end

  // signed offsets of the pixel center, in half pixels
  logic signed [DW+1:0] nu_s, nv_s;
  assign nu_s = $signed({2'b00, s0_col, 1'b1}) - $signed({2'b00, w_eff});
  assign nv_s = $signed({2'b00, img_h}) - $signed({2'b00, s0_row, 1'b1});

  logic                        s1_v;
  logic [ppr_pkg::NMAG_W-1:0]  s1_umag, s1_vmag;
  logic                        s1_uneg, s1_vneg;

  always_ff @(posedge clk) begin
    if (rst) s1_v <= 1'b0;
    else if (en) s1_v <= s0_v;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s1_uneg <= nu_s[DW+1];
      s1_vneg <= nv_s[DW+1];
      s1_umag <= nu_s[DW+1] ? ppr_pkg::NMAG_W'(-nu_s) : nu_s[ppr_pkg::NMAG_W-1:0];
      s1_vmag <= nv_s[DW+1] ? ppr_pkg::NMAG_W'(-nv_s) : nv_s[ppr_pkg::NMAG_W-1:0];
    end
  end

  // u = floor((8|n|t + w) / 2w), restoring division one quotient bit per stage
  localparam int PT_W = ppr_pkg::NMAG_W + ppr_pkg::TAN_W;
  logic [PT_W-1:0]  pu, pv;
  logic [UQ:0]      num_u, num_v;
  logic [UR:0]      d_u;
  assign pu    = PT_W'(s1_umag) * PT_W'(fov_tan);
  assign pv    = PT_W'(s1_vmag) * PT_W'(fov_tan);
  assign num_u = {pu, 3'b000} + (UQ+1)'(w_eff);
  assign num_v = {pv, 3'b000} + (UQ+1)'(w_eff);
  assign d_u   = {1'b0, w_eff, 1'b0};

  logic          dv  [0:UQ];
  logic [UR-1:0] dur [0:UQ];
  logic [UR-1:0] dvr [0:UQ];
  logic [UQ-1:0] dux [0:UQ];
  logic [UQ-1:0] dvx [0:UQ];
  logic          dun [0:UQ];
  logic          dvn [0:UQ];

  always_ff @(posedge clk) begin
    if (rst) dv[0] <= 1'b0;
    else if (en) dv[0] <= s1_v;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      dur[0] <= UR'(num_u[UQ]);
      dvr[0] <= UR'(num_v[UQ]);
      dux[0] <= num_u[UQ-1:0];
      dvx[0] <= num_v[UQ-1:0];
      dun[0] <= s1_uneg;
      dvn[0] <= s1_vneg;
    end
  end

  for (genvar j = 0; j < UQ; j++) begin : g_uv_div
    logic [UR:0] tu, tv;
    logic        geu, gev;
    assign tu  = {dur[j], dux[j][UQ-1]};
    assign tv  = {dvr[j], dvx[j][UQ-1]};
    assign geu = tu >= d_u;
    assign gev = tv >= d_u;
    always_ff @(posedge clk) begin
      if (rst) dv[j+1] <= 1'b0;
      else if (en) dv[j+1] <= dv[j];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        dur[j+1] <= geu ? UR'(tu - d_u) : tu[UR-1:0];
        dvr[j+1] <= gev ? UR'(tv - d_u) : tv[UR-1:0];
        dux[j+1] <= {dux[j][UQ-2:0], geu};
        dvx[j+1] <= {dvx[j][UQ-2:0], gev};
        dun[j+1] <= dun[j];
        dvn[j+1] <= dvn[j];
      end
    end
  end

  // signed plane coordinates
  logic                                uv_v;
  logic signed [ppr_pkg::UV_W-1:0]     uv_u, uv_w;

  always_ff @(posedge clk) begin
    if (rst) uv_v <= 1'b0;
    else if (en) uv_v <= dv[UQ];
  end
  always_ff @(posedge clk) begin
    if (en) begin
      uv_u <= dun[UQ] ? -$signed({1'b0, dux[UQ]}) : $signed({1'b0, dux[UQ]});
      uv_w <= dvn[UQ] ? -$signed({1'b0, dvx[UQ]}) : $signed({1'b0, dvx[UQ]});
    end
  end

  // axis products, guard rounding, plane point
  logic                                  m1_v, m2_v, m3_v, m4_v;
  logic signed [ppr_pkg::PROD_W-1:0]     m1_r [3];
  logic signed [ppr_pkg::PROD_W-1:0]     m1_s [3];
  logic signed [PW-1:0]                  m2_r [3];
  logic signed [PW-1:0]                  m2_s [3];
  logic signed [PW-1:0]                  m3_p [3];
  logic [PW-1:0]                         m4_mag [3];
  logic [2:0]                            m4_neg;

  always_ff @(posedge clk) begin
    if (rst) begin
      m1_v <= 1'b0;
      m2_v <= 1'b0;
      m3_v <= 1'b0;
      m4_v <= 1'b0;
    end else if (en) begin
      m1_v <= uv_v;
      m2_v <= m1_v;
      m3_v <= m2_v;
      m4_v <= m3_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        m1_r[i]   <= ppr_pkg::PROD_W'(ppr_pkg::vec_comp(right_vec, 2'(i))) *
                     ppr_pkg::PROD_W'(uv_u);
        m1_s[i]   <= ppr_pkg::PROD_W'(ppr_pkg::vec_comp(up_vec, 2'(i))) *
                     ppr_pkg::PROD_W'(uv_w);
        m2_r[i]   <= ppr_pkg::round_guard(m1_r[i]);
        m2_s[i]   <= ppr_pkg::round_guard(m1_s[i]);
        m3_p[i]   <= (PW'(ppr_pkg::vec_comp(view_vec, 2'(i))) <<<
                      (ppr_pkg::FRAC + ppr_pkg::GUARD)) + m2_r[i] + m2_s[i];
        m4_mag[i] <= m3_p[i][PW-1] ? PW'(-m3_p[i]) : PW'(m3_p[i]);
        m4_neg[i] <= m3_p[i][PW-1];
      end
    end
  end

  // largest magnitude
  logic [PW-1:0] max_c;
  always_comb begin
    max_c = m4_mag[0];
    if (m4_mag[1] > max_c) max_c = m4_mag[1];
    if (m4_mag[2] > max_c) max_c = m4_mag[2];
  end

  logic           m5_v;
  logic [PW-1:0]  m5_max;
  logic [PW-1:0]  m5_mag [3];
  logic [2:0]     m5_neg;

  always_ff @(posedge clk) begin
    if (rst) m5_v <= 1'b0;
    else if (en) m5_v <= m4_v;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      m5_max <= max_c;
      m5_mag <= m4_mag;
      m5_neg <= m4_neg;
    end
  end

  // bit length search, first per chunk
  logic [3:0]       clen [NCH];
  logic [NCH-1:0]   cany;
  always_comb begin
    for (int c = 0; c < NCH; c++) begin
      clen[c] = '0;
      cany[c] = |m5_max[c*CHK +: CHK];
      for (int b = 0; b < CHK; b++) begin
        if (m5_max[c*CHK + b]) clen[c] = 4'(b + 1);
      end
    end
  end

  logic             m6_v;
  logic [3:0]       m6_len [NCH];
  logic [NCH-1:0]   m6_any;
  logic [PW-1:0]    m6_mag [3];
  logic [2:0]       m6_neg;

  always_ff @(posedge clk) begin
    if (rst) m6_v <= 1'b0;
    else if (en) m6_v <= m5_v;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      m6_len <= clen;
      m6_any <= cany;
      m6_mag <= m5_mag;
      m6_neg <= m5_neg;
    end
  end

  // then across chunks, giving shift direction and amount
  logic [5:0] blen;
  logic       shr_c;
  logic [4:0] k_c;
  always_comb begin
    blen = '0;
    for (int c = 0; c < NCH; c++) begin
      if (m6_any[c]) blen = 6'(c * CHK) + 6'(m6_len[c]);
    end
    shr_c = blen > 6'(ppr_pkg::NORM_TOP);
    k_c   = shr_c ? 5'(blen - 6'(ppr_pkg::NORM_TOP)) : 5'(6'(ppr_pkg::NORM_TOP) - blen);
  end

  logic           m7_v;
  logic           m7_shr;
  logic [4:0]     m7_k;
  logic [PW-1:0]  m7_mag [3];
  logic [2:0]     m7_neg;

  always_ff @(posedge clk) begin
    if (rst) m7_v <= 1'b0;
    else if (en) m7_v <= m6_v;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      m7_shr <= shr_c;
      m7_k   <= k_c;
      m7_mag <= m6_mag;
      m7_neg <= m6_neg;
    end
  end

  // scale a nonzero largest magnitude into [2^29, 2^30], right shifts round half up
  logic [NW-1:0] nm_c [3];
  logic [PW-1:0] shr_t [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      shr_t[i] = m7_mag[i] >> 5'(m7_k - 5'd1);
      if (m7_shr) nm_c[i] = NW'(PW'(shr_t[i] + PW'(1)) >> 1);
      else nm_c[i] = NW'(m7_mag[i] << m7_k);
    end
  end

  logic           m8_v;
  logic [NW-1:0]  m8_nm [3];
  logic [2:0]     m8_neg;

  always_ff @(posedge clk) begin
    if (rst) m8_v <= 1'b0;
    else if (en) m8_v <= m7_v;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      m8_nm  <= nm_c;
      m8_neg <= m7_neg;
    end
  end

  // squares
  logic           sq_v;
  logic [SW-1:0]  sq [3];
  logic [NW-1:0]  sq_nm [3];
  logic [2:0]     sq_neg;

  always_ff @(posedge clk) begin
    if (rst) sq_v <= 1'b0;
    else if (en) sq_v <= m8_v;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) sq[i] <= SW'(m8_nm[i]) * SW'(m8_nm[i]);
      sq_nm  <= m8_nm;
      sq_neg <= m8_neg;
    end
  end

  // floor square root, two radicand bits per stage
  logic           rv    [0:SQN];
  logic [NW+1:0]  rrem  [0:SQN];
  logic [NW-1:0]  rroot [0:SQN];
  logic [SW-1:0]  rbits [0:SQN];
  logic [NW-1:0]  rnm   [0:SQN][3];
  logic [2:0]     rneg  [0:SQN];

  always_ff @(posedge clk) begin
    if (rst) rv[0] <= 1'b0;
    else if (en) rv[0] <= sq_v;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      rrem[0]  <= '0;
      rroot[0] <= '0;
      rbits[0] <= sq[0] + sq[1] + sq[2];
      rnm[0]   <= sq_nm;
      rneg[0]  <= sq_neg;
    end
  end

  for (genvar j = 0; j < SQN; j++) begin : g_sqrt
    logic [NW+3:0] rem2, trial;
    logic          ge;
    assign rem2  = {rrem[j], rbits[j][SW-1:SW-2]};
    assign trial = {2'b00, rroot[j], 2'b01};
    assign ge    = rem2 >= trial;
    always_ff @(posedge clk) begin
      if (rst) rv[j+1] <= 1'b0;
      else if (en) rv[j+1] <= rv[j];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rrem[j+1]  <= ge ? (NW+2)'(rem2 - trial) : rem2[NW+1:0];
        rroot[j+1] <= {rroot[j][NW-2:0], ge};
        rbits[j+1] <= {rbits[j][SW-3:0], 2'b00};
        rnm[j+1]   <= rnm[j];
        rneg[j+1]  <= rneg[j];
      end
    end
  end

  // component / norm, rounded half up, one quotient bit per stage
  logic [NW-1:0]  norm_c;
  logic [FNW-1:0] fnum [3];
  assign norm_c = (rroot[SQN] == '0) ? NW'(1) : rroot[SQN];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      fnum[i] = {rnm[SQN][i], {ppr_pkg::FRAC{1'b0}}} + FNW'(norm_c >> 1);
    end
  end

  logic           fv    [0:FQ];
  logic [NW-1:0]  frem  [0:FQ][3];
  logic [FQ-1:0]  fquo  [0:FQ][3];
  logic [NW-1:0]  fnorm [0:FQ];
  logic [2:0]     fneg  [0:FQ];

  always_ff @(posedge clk) begin
    if (rst) fv[0] <= 1'b0;
    else if (en) fv[0] <= rv[SQN];
  end
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        frem[0][i] <= NW'(fnum[i][FNW-1:FQ]);
        fquo[0][i] <= fnum[i][FQ-1:0];
      end
      fnorm[0] <= norm_c;
      fneg[0]  <= rneg[SQN];
    end
  end

  for (genvar j = 0; j < FQ; j++) begin : g_norm_div
    logic [NW:0] t2 [3];
    logic [2:0]  ge;
    always_comb begin
      for (int i = 0; i < 3; i++) begin
        t2[i] = {frem[j][i], fquo[j][i][FQ-1]};
        ge[i] = t2[i] >= {1'b0, fnorm[j]};
      end
    end
    always_ff @(posedge clk) begin
      if (rst) fv[j+1] <= 1'b0;
      else if (en) fv[j+1] <= fv[j];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        for (int i = 0; i < 3; i++) begin
          frem[j+1][i] <= ge[i] ? NW'(t2[i] - {1'b0, fnorm[j]}) : t2[i][NW-1:0];
          fquo[j+1][i] <= {fquo[j][i][FQ-2:0], ge[i]};
        end
        fnorm[j+1] <= fnorm[j];
        fneg[j+1]  <= fneg[j];
      end
    end
  end

  // saturate to one and apply sign
  localparam logic [FQ-1:0] ONE_Q = FQ'(1 << ppr_pkg::FRAC);
  logic [VW-1:0]  dir_c [3];
  logic [FQ-1:0]  sat_c [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sat_c[i] = (fquo[FQ][i] > ONE_Q) ? ONE_Q : fquo[FQ][i];
      dir_c[i] = fneg[FQ][i] ? VW'(-sat_c[i]) : VW'(sat_c[i]);
    end
  end

  logic          fin_v;
  ppr_pkg::ray_t fin_d;

  always_ff @(posedge clk) begin
    if (rst) fin_v <= 1'b0;
    else if (en) fin_v <= fv[FQ];
  end
  always_ff @(posedge clk) begin
    if (en) begin
      fin_d.dir_x <= dir_c[0];
      fin_d.dir_y <= dir_c[1];
      fin_d.dir_z <= dir_c[2];
    end
  end

  // output register with skid stage
  always_ff @(posedge clk) begin
    if (rst) begin
      ray_valid <= 1'b0;
      skid_v    <= 1'b0;
    end else if (!ray_valid || !ray_stall) begin
      if (skid_v) begin
        ray       <= skid_d;
        ray_valid <= 1'b1;
        skid_v    <= 1'b0;
      end else begin
        ray       <= fin_d;
        ray_valid <= fin_v;
      end
    end else if (!skid_v) begin
      skid_d <= fin_d;
      skid_v <= fin_v;
    end
  end

  `ASSERT_CLK(a_skid_behind_out, skid_v |-> ray_valid, "skid holds an item but output is empty")
  `ASSERT_CLK(a_skid_fill, $rose(skid_v) |-> $past(ray_valid && ray_stall), "skid filled without a stall")
  `ASSERT_CLK(a_unit_x, ray_valid |-> ($signed(ray.dir_x) <= 16'sd16384 && $signed(ray.dir_x) >= -16'sd16384), "dir_x out of unit range")

endmodule

// File: test/ppr_checker.sv
// checker: predicts each ray direction from the pixel items and compares results
`timescale 1ns / 1ps

module ppr_checker (
  input  logic          clk,
  input  logic          rst,
  input  logic          pix_valid,
  input  logic          pix_stall,
  input  ppr_pkg::pix_t pix,
  input  logic          ray_valid,
  input  logic          ray_stall,
  input  ppr_pkg::ray_t ray,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic          pready,
  input  logic [5:0]    paddr,
  input  logic [63:0]   pwdata,
  output int            fail_count,
  output int            rays_pending
);

  logic [12:0] width_r, height_r;
  logic [15:0] fov_tan_r;
  logic [47:0] view_r, right_r, up_r;
  ppr_pkg::ray_t expected_rays[$];

  assign rays_pending = expected_rays.size();

  function automatic longint round_div(longint num, longint den);
    longint m, q;
    m = (num < 0) ? -num : num;
    q = (m + den / 2) / den;
    return (num < 0) ? -q : q;
  endfunction

  function automatic longint comp(logic [47:0] v, int idx);
    logic signed [15:0] c;
    c = v[16*idx +: 16];
    return longint'(c);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned s);
    longint unsigned res, bit_v;
    res = 0;
    bit_v = 64'd1 << 62;
    while (bit_v > s) bit_v >>= 2;
    while (bit_v != 0) begin
      if (s >= res + bit_v) begin
        s -= res + bit_v;
        res = (res >> 1) + bit_v;
      end else begin
        res >>= 1;
      end
      bit_v >>= 2;
    end
    return res;
  endfunction

  function automatic ppr_pkg::ray_t predict_ray(ppr_pkg::pix_t px);
    longint w, h, t, den, u, v;
    longint p[3];
    longint unsigned mag[3], maxm, sum, norm, q;
    bit neg[3];
    int k;
    ppr_pkg::ray_t r;
    w = width_r;
    h = height_r;
    t = fov_tan_r;
    if (w == 0) w = 1;
    den = w << 12;
    u = round_div((2 * longint'(px.pixel_col) + 1 - w) * t * (64'sd1 << ppr_pkg::FRAC), den);
    v = round_div((h - 2 * longint'(px.pixel_row) - 1) * t * (64'sd1 << ppr_pkg::FRAC), den);
    maxm = 0;
    for (int i = 0; i < 3; i++) begin
      p[i] = comp(view_r, i) * (64'sd1 << (ppr_pkg::FRAC + ppr_pkg::GUARD))
           + round_div(comp(right_r, i) * u, 64'sd1 << (ppr_pkg::FRAC - ppr_pkg::GUARD))
           + round_div(comp(up_r, i) * v, 64'sd1 << (ppr_pkg::FRAC - ppr_pkg::GUARD));
      neg[i] = p[i] < 0;
      mag[i] = neg[i] ? -p[i] : p[i];
      if (mag[i] > maxm) maxm = mag[i];
    end
    r = '0;
    if (maxm == 0) return r;
    k = 0;
    if (maxm >= (64'd1 << 30)) begin
      while ((maxm >> k) >= (64'd1 << 30)) k++;
      for (int i = 0; i < 3; i++) mag[i] = (mag[i] + (64'd1 << (k - 1))) >> k;
    end else begin
      while ((maxm << k) < (64'd1 << 29)) k++;
      for (int i = 0; i < 3; i++) mag[i] <<= k;
    end
    sum = 0;
    for (int i = 0; i < 3; i++) sum += mag[i] * mag[i];
    norm = int_sqrt(sum);
    if (norm == 0) norm = 1;
    for (int i = 0; i < 3; i++) begin
      q = ((mag[i] << ppr_pkg::FRAC) + norm / 2) / norm;
      if (q > (64'd1 << ppr_pkg::FRAC)) q = 64'd1 << ppr_pkg::FRAC;
      if (neg[i]) q = -q;
      case (i)
        0: r.dir_x = q[15:0];
        1: r.dir_y = q[15:0];
        default: r.dir_z = q[15:0];
      endcase
    end
    return r;
  endfunction

  always @(posedge clk) begin
    ppr_pkg::ray_t e;
    int errs;
    errs = 0;
    if (rst) begin
      width_r <= 13'd640;
      height_r <= 13'd480;
      fov_tan_r <= 16'd4096;
      view_r <= '0;
      right_r <= '0;
      up_r <= '0;
      fail_count <= 0;
      expected_rays.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (ppr_pkg::cfg_reg_t'(paddr[5:3]))
          ppr_pkg::CFG_WIDTH:   width_r <= pwdata[12:0];
          ppr_pkg::CFG_HEIGHT:  height_r <= pwdata[12:0];
          ppr_pkg::CFG_FOV_TAN: fov_tan_r <= pwdata[15:0];
          ppr_pkg::CFG_VIEW:    view_r <= pwdata[47:0];
          ppr_pkg::CFG_RIGHT:   right_r <= pwdata[47:0];
          ppr_pkg::CFG_UP:      up_r <= pwdata[47:0];
          default: ;
        endcase
      end
      if (pix_valid && !pix_stall) expected_rays.push_back(predict_ray(pix));
      if (ray_valid && !ray_stall) begin
        if (expected_rays.size() == 0) begin
          $error("ray item with no expectation: %h", ray);
          errs++;
        end else begin
          e = expected_rays.pop_front();
          if (e.dir_x !== ray.dir_x) begin
            $error("dir_x expected %0d actual %0d", e.dir_x, ray.dir_x);
            errs++;
          end
          if (e.dir_y !== ray.dir_y) begin
            $error("dir_y expected %0d actual %0d", e.dir_y, ray.dir_y);
            errs++;
          end
          if (e.dir_z !== ray.dir_z) begin
            $error("dir_z expected %0d actual %0d", e.dir_z, ray.dir_z);
            errs++;
          end
        end
      end
      if (errs != 0) fail_count <= fail_count + errs;
    end
  end
endmodule

// File: test/tb.sv
// testbench top: drives pixel items and register writes, gives the verdict
`timescale 1ns / 1ps

module tb;

  logic clk = 0, rst = 1;
  logic pix_valid = 0, pix_stall, ray_valid, ray_stall = 0;
  ppr_pkg::pix_t pix = '0;
  ppr_pkg::ray_t ray;
  logic psel = 0, penable = 0, pwrite = 0, pready;
  logic [5:0] paddr = '0;
  logic [63:0] pwdata = '0, prdata;
  int fail_count, rays_pending;
  int send_idle = 0, recv_idle = 0;
  bit hold_recv = 0;
  longint cycles = 0;

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  pinhole_primary_ray_direction_top uut (.*);
  ppr_checker chk (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 2000000) begin
      $display("FAIL pinhole_primary_ray_direction_top");
      $finish;
    end
  end

  // receiver stall, random or held off for a long stretch
  always @(negedge clk) begin
    ray_stall <= hold_recv || ($urandom_range(99) < recv_idle);
  end

  task automatic write_reg(ppr_pkg::cfg_reg_t idx, logic [63:0] val);
    psel <= 1; pwrite <= 1; penable <= 0;
    paddr <= 6'(idx) << 3; pwdata <= val;
    @(negedge clk);
    penable <= 1;
    do @(negedge clk); while (!pready);
    psel <= 0; penable <= 0; pwrite <= 0;
    @(negedge clk);
  endtask

  task automatic drain;
    pix_valid <= 0;
    while (rays_pending != 0) @(negedge clk);
    repeat (110) @(negedge clk);
  endtask

  // valid stays up after an item so the next one can follow at once
  task automatic send_pix(logic [11:0] col, logic [11:0] row);
    while ($urandom_range(99) < send_idle) begin
      pix_valid <= 0;
      @(negedge clk);
    end
    pix_valid <= 1;
    pix.pixel_col <= col;
    pix.pixel_row <= row;
    @(posedge clk);
    while (pix_stall) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [15:0] rand_comp();
    case ($urandom_range(5))
      0: return 16'sd16384;
      1: return -16'sd16384;
      2: return 16'sh7fff;
      3: return 16'sh8000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [47:0] rand_vec();
    return {rand_comp(), rand_comp(), rand_comp()};
  endfunction

  task automatic rand_config(int mode);
    logic [12:0] w;
    w = (mode == 0) ? 13'($urandom_range(1, 64)) :
        (mode == 1) ? 13'd4096 : 13'($urandom_range(0, 8191));
    write_reg(ppr_pkg::CFG_WIDTH, 64'(w));
    write_reg(ppr_pkg::CFG_HEIGHT, 64'((mode == 1) ? 13'd0 : 13'($urandom)));
    write_reg(ppr_pkg::CFG_FOV_TAN, 64'((mode == 1) ? 16'hffff : 16'($urandom)));
    write_reg(ppr_pkg::CFG_VIEW, 64'(rand_vec()));
    write_reg(ppr_pkg::CFG_RIGHT, 64'(rand_vec()));
    write_reg(ppr_pkg::CFG_UP, 64'(rand_vec()));
  endtask

  task automatic rand_items(int n, int wlim);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(3) == 0) send_pix(12'($urandom), 12'($urandom));
      else send_pix(12'($urandom_range(wlim)), 12'($urandom_range(wlim)));
    end
  endtask

  initial begin
    repeat (9) @(negedge clk);
    rst <= 0;
    @(negedge clk);
    // all vectors at reset give the zero direction
    send_pix(12'd0, 12'd0);
    send_pix(12'd4095, 12'd4095);
    drain();
    write_reg(ppr_pkg::CFG_VIEW, 64'({16'sd16384, 16'd0, 16'd0}));
    write_reg(ppr_pkg::CFG_RIGHT, 64'({16'd0, 16'd0, 16'sd16384}));
    write_reg(ppr_pkg::CFG_UP, 64'({16'd0, 16'sd16384, 16'd0}));
    send_pix(12'd0, 12'd0);
    send_pix(12'd639, 12'd479);
    send_pix(12'd320, 12'd240);
    send_pix(12'd4095, 12'd0);
    send_pix(12'd0, 12'd4095);
    drain();
    // zero width, zero height, extreme tangent
    write_reg(ppr_pkg::CFG_WIDTH, 64'd0);
    write_reg(ppr_pkg::CFG_HEIGHT, 64'd0);
    write_reg(ppr_pkg::CFG_FOV_TAN, 64'hffff);
    send_pix(12'd0, 12'd0);
    send_pix(12'd4095, 12'd4095);
    drain();
    write_reg(ppr_pkg::CFG_WIDTH, 64'd4096);
    write_reg(ppr_pkg::CFG_HEIGHT, 64'd4096);
    write_reg(ppr_pkg::CFG_FOV_TAN, 64'd0);
    drain();
    send_pix(12'd4095, 12'd4095);
    send_pix(12'd0, 12'd0);
    drain();
    write_reg(ppr_pkg::CFG_FOV_TAN, 64'hffff);
    write_reg(ppr_pkg::CFG_VIEW, 64'({16'h8000, 16'h8000, 16'h8000}));
    write_reg(ppr_pkg::CFG_RIGHT, 64'({16'h7fff, 16'h7fff, 16'h7fff}));
    write_reg(ppr_pkg::CFG_UP, 64'({16'h8000, 16'h7fff, 16'h8000}));
    send_pix(12'd0, 12'd4095);
    send_pix(12'd4095, 12'd0);
    send_pix(12'd2048, 12'd2048);
    drain();

    for (int ph = 0; ph < 12; ph++) begin
      if (ph < 4) begin send_idle = 11; recv_idle = 61; end
      else if (ph < 8) begin send_idle = 61; recv_idle = 11; end
      else begin send_idle = 0; recv_idle = 0; end
      rand_config(ph % 3);
      if (ph == 9) begin
        // receiver holds off long enough for the pipeline to back up
        fork
          begin
            hold_recv = 1;
            repeat (300) @(negedge clk);
            hold_recv = 0;
          end
          rand_items(115, 4095);
        join
      end else begin
        rand_items(115, (ph % 3 == 0) ? 64 : 4095);
      end
      drain();
    end
    if (fail_count == 0) $display("PASS pinhole_primary_ray_direction_top");
    else $display("FAIL pinhole_primary_ray_direction_top");
    $finish;
  end
endmodule

// File: pinhole_primary_ray_direction_top.f
+incdir+hdl
hdl/ppr_pkg.sv
hdl/pinhole_primary_ray_direction_top.sv
test/ppr_checker.sv
test/tb.sv
